### design/sfcd_pkg.sv
// Shared types, constants and CRC function for the sensor frame decoder.
package sfcd_pkg;

    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [2:0]  POS_CRC_SPAN  = 3'd6;
    localparam logic [2:0]  POS_STORE_LO  = 3'd2;
    localparam logic [2:0]  POS_LAST      = 3'd7;
    localparam int          STORE_DEPTH   = 5;
    localparam logic [7:0]  TEMP_MAG_MASK = 8'h7F;
    localparam logic [7:0]  TEMP_SIGN     = 8'h80;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_first;
    } t_beat;

    typedef struct packed {
        logic              frame_status;
        logic signed [15:0] temperature_tenths;
        logic [15:0]       humidity_tenths;
    } t_result;

    // reflected CRC-16 byte update, one bit per step
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/sfcd_in_reg.sv
// Input beat register: holds one received byte until the frame core takes it.
module sfcd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sfcd_pkg::t_beat i_beat,
    output logic            o_valid,
    output sfcd_pkg::t_beat o_beat,
    input  logic            i_take
);

    logic            r_vld;
    logic            n_vld;
    sfcd_pkg::t_beat r_beat;
    logic            s_load;

    assign o_ready = !r_vld || i_take;
    assign s_load  = i_valid && o_ready;

    always_comb begin
        if (s_load) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_vld;
    assign o_beat  = r_beat;

endmodule

### design/sfcd_frame_core.sv
// Frame core: byte position, running CRC, stored payload bytes and decode.
module sfcd_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  sfcd_pkg::t_beat   i_beat,
    output logic              o_is_last,
    output sfcd_pkg::t_result o_result
);

    logic [2:0]  r_pos;
    logic [2:0]  n_pos;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_bytes [sfcd_pkg::STORE_DEPTH];

    logic [2:0]  s_pos;
    logic [15:0] s_crc_base;
    logic [2:0]  s_idx;
    logic [15:0] s_got;
    logic [15:0] s_mag;
    logic [15:0] s_temp;

    assign s_pos      = i_beat.frame_first ? 3'd0 : r_pos;
    assign s_crc_base = i_beat.frame_first ? sfcd_pkg::CRC_SEED : r_crc;
    assign s_idx      = s_pos - sfcd_pkg::POS_STORE_LO;
    assign o_is_last  = (s_pos == sfcd_pkg::POS_LAST);

    always_comb begin
        if (o_is_last) begin
            n_pos = 3'd0;
            n_crc = sfcd_pkg::CRC_SEED;
        end else begin
            n_pos = s_pos + 3'd1;
            n_crc = (s_pos < sfcd_pkg::POS_CRC_SPAN) ?
                    sfcd_pkg::crc16_byte(s_crc_base, i_beat.rx_byte) : s_crc_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
            r_crc <= sfcd_pkg::CRC_SEED;
        end else if (i_take) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && (s_pos >= sfcd_pkg::POS_STORE_LO) && !o_is_last) begin
            r_bytes[s_idx] <= i_beat.rx_byte;
        end
    end

    // bytes 2..6 live at entries 0..4
    assign s_got  = {i_beat.rx_byte, r_bytes[4]};
    assign s_mag  = {r_bytes[2] & sfcd_pkg::TEMP_MAG_MASK, r_bytes[3]};
    assign s_temp = ((r_bytes[2] & sfcd_pkg::TEMP_SIGN) != 8'h00) ? (16'h0000 - s_mag) : s_mag;

    always_comb begin
        if (s_got == s_crc_base) begin
            o_result.frame_status       = 1'b0;
            o_result.temperature_tenths = $signed(s_temp);
            o_result.humidity_tenths    = {r_bytes[0], r_bytes[1]};
        end else begin
            o_result.frame_status       = 1'b1;
            o_result.temperature_tenths = 16'sd0;
            o_result.humidity_tenths    = 16'd0;
        end
    end

endmodule

### design/sfcd_out_reg.sv
// Result register: holds one decoded frame until the receiver takes it.
module sfcd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfcd_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output sfcd_pkg::t_result o_result
);

    logic              r_vld;
    logic              n_vld;
    sfcd_pkg::t_result r_result;

    always_comb begin
        if (i_load) begin
            n_vld = 1'b1;
        end else if (i_ready) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_result;

endmodule

### design/sensor_frame_crc_decoder.sv
// Top level of the sensor frame CRC decoder.
//
// Input channel: one frame byte per beat on i_rx_byte, with i_frame_first set
// on byte 0 to restart the frame. Without the flag, bytes are counted
// modulo 8 from reset or from the end of the previous frame.
// Output channel: one beat per complete 8-byte frame, carrying the CRC
// status and, on a match, humidity and signed temperature in tenths.
// Throughput: one byte per cycle, except while a held result stalls byte 7.
// A taken beat is held in the input register; the core decodes it there and
// loads the frame result into the result register, which drives the outputs.
// The byte-wide CRC update sits between the input and core registers.
// Reset clears the byte position, seeds the CRC with 0xFFFF and empties
// both the input and the result registers.
// When the receiver stalls, the result is held and the input register keeps
// taking bytes 0 to 6 of the next frame; byte 7 waits in the input register
// and ready stays low until the held result is taken.
module sensor_frame_crc_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_first,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_frame_status,
    output logic signed [15:0] o_temperature_tenths,
    output logic [15:0]        o_humidity_tenths
);

    sfcd_pkg::t_beat   s_in_beat;
    sfcd_pkg::t_beat   s_core_beat;
    sfcd_pkg::t_result s_core_result;
    sfcd_pkg::t_result s_out_result;
    logic              s_core_valid;
    logic              s_is_last;
    logic              s_take;
    logic              s_load;

    assign s_in_beat.rx_byte     = i_rx_byte;
    assign s_in_beat.frame_first = i_frame_first;

    assign s_take = s_core_valid && (!s_is_last || !o_out_valid || i_out_ready);
    assign s_load = s_take && s_is_last;

    sfcd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (s_in_beat),
        .o_valid (s_core_valid),
        .o_beat  (s_core_beat),
        .i_take  (s_take)
    );

    sfcd_frame_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (s_take),
        .i_beat    (s_core_beat),
        .o_is_last (s_is_last),
        .o_result  (s_core_result)
    );

    sfcd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_load),
        .i_result (s_core_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (s_out_result)
    );

    assign o_frame_status       = s_out_result.frame_status;
    assign o_temperature_tenths = s_out_result.temperature_tenths;
    assign o_humidity_tenths    = s_out_result.humidity_tenths;

endmodule

### design/sfcd_checker.sv
// Port-level checker for the sensor frame CRC decoder, with its bind.
module sfcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_frame_status,
    input logic signed [15:0] o_temperature_tenths,
    input logic [15:0]        o_humidity_tenths
);

    // held result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_temperature_tenths)
            && $stable(o_humidity_tenths) && $stable(o_frame_status))
        else $error("result beat dropped or changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status |-> o_temperature_tenths == 16'sd0
            && o_humidity_tenths == 16'd0)
        else $error("mismatch beat carries nonzero data");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_temperature_tenths != 16'sh8000)
        else $error("temperature out of sign-magnitude range");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind sensor_frame_crc_decoder sfcd_checker u_sfcd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_frame_status       (o_frame_status),
    .o_temperature_tenths (o_temperature_tenths),
    .o_humidity_tenths    (o_humidity_tenths)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sensor frame CRC decoder: frame stimulus, scoreboard, checks.
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 800;
    localparam int NUM_PHASES     = 4;
    localparam int TAIL_CYCLES    = 8;

    typedef logic [7:0][7:0] t_frame;

    class sensor_reading_model;
        logic [2:0]          position;
        logic [15:0]         crc;
        logic [7:0]          held [sfcd_pkg::STORE_DEPTH];
        sfcd_pkg::t_result   expected_readings [$];
        int unsigned         mismatches;

        function new();
            position   = '0;
            crc        = sfcd_pkg::CRC_SEED;
            mismatches = 0;
            foreach (held[i]) held[i] = '0;
        endfunction

        // bit-serial form, LSB first
        static function logic [15:0] crc16_step(logic [15:0] c_in, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = c_in;
            for (int k = 0; k < 8; k++) begin
                fb = c[0] ^ b[k];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ sfcd_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        function void take_byte(logic [7:0] b, logic first);
            logic [15:0]       magnitude;
            sfcd_pkg::t_result r;
            if (first) begin
                position = '0;
                crc      = sfcd_pkg::CRC_SEED;
            end
            if (position < sfcd_pkg::POS_CRC_SPAN) begin
                crc = crc16_step(crc, b);
            end
            if (position >= sfcd_pkg::POS_STORE_LO && position < sfcd_pkg::POS_LAST) begin
                held[position - sfcd_pkg::POS_STORE_LO] = b;
            end
            if (position != sfcd_pkg::POS_LAST) begin
                position = position + 3'd1;
                return;
            end
            if ({b, held[4]} == crc) begin
                magnitude            = {1'b0, held[2][6:0], held[3]};
                r.frame_status       = 1'b0;
                r.temperature_tenths = ((held[2] & sfcd_pkg::TEMP_SIGN) != 0) ?
                                       -magnitude : magnitude;
                r.humidity_tenths    = {held[0], held[1]};
            end else begin
                r.frame_status       = 1'b1;
                r.temperature_tenths = '0;
                r.humidity_tenths    = '0;
            end
            expected_readings.push_back(r);
            position = '0;
            crc      = sfcd_pkg::CRC_SEED;
        endfunction

        task check_reading(logic status, logic [15:0] temp, logic [15:0] hum);
            sfcd_pkg::t_result e;
            if (expected_readings.size() == 0) begin
                report("result beat with no frame pending");
                return;
            end
            e = expected_readings.pop_front();
            if (status !== e.frame_status) begin
                report($sformatf("frame_status: got %0b, expected %0b", status, e.frame_status));
            end
            if (temp !== e.temperature_tenths) begin
                report($sformatf("temperature_tenths: got %0d, expected %0d",
                                 $signed(temp), e.temperature_tenths));
            end
            if (hum !== e.humidity_tenths) begin
                report($sformatf("humidity_tenths: got %0d, expected %0d",
                                 hum, e.humidity_tenths));
            end
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [7:0]         i_rx_byte     = '0;
    logic               i_frame_first = 1'b0;
    logic               i_out_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_frame_status;
    logic signed [15:0] o_temperature_tenths;
    logic [15:0]        o_humidity_tenths;

    sensor_reading_model readings = new();

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int beats_sent    = 0;
    int quiet_cycles  = 0;
    bit synced        = 1'b1;

    int phase_in_idle   [NUM_PHASES] = '{0, 85, 0, 13};
    int phase_out_stall [NUM_PHASES] = '{0, 0, 85, 13};

    sensor_frame_crc_decoder i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_rx_byte            (i_rx_byte),
        .i_frame_first        (i_frame_first),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_frame_status       (o_frame_status),
        .o_temperature_tenths (o_temperature_tenths),
        .o_humidity_tenths    (o_humidity_tenths)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            readings.check_reading(o_frame_status, o_temperature_tenths, o_humidity_tenths);
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_beat(logic [7:0] b, logic first);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_first <= first;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        readings.take_byte(b, first);
        beats_sent++;
    endtask

    task send_frame(t_frame fr, int len, logic first);
        for (int i = 0; i < len; i++) begin
            send_beat(fr[i], (i == 0) ? first : 1'b0);
        end
    endtask

    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (readings.expected_readings.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_frame make_frame(logic [15:0] hum, logic [15:0] temp_raw, bit good);
        t_frame      fr;
        logic [15:0] crc;
        fr[0] = 8'($urandom_range(255));
        fr[1] = 8'($urandom_range(255));
        fr[2] = hum[15:8];
        fr[3] = hum[7:0];
        fr[4] = temp_raw[15:8];
        fr[5] = temp_raw[7:0];
        crc   = sfcd_pkg::CRC_SEED;
        for (int i = 0; i < 6; i++) begin
            crc = sensor_reading_model::crc16_step(crc, fr[i]);
        end
        if (!good) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        fr[6] = crc[7:0];
        fr[7] = crc[15:8];
        return fr;
    endfunction

    function automatic logic [15:0] pick_word();
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       return 16'h0000;
                1:       return 16'h7FFF;
                2:       return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task random_traffic(int target);
        int  pick;
        int  n;
        bit  flag;
        while (beats_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                flag = synced ? 1'($urandom_range(1)) : 1'b1;
                send_frame(make_frame(pick_word(), pick_word(), pick < 60), 8, flag);
                synced = 1'b1;
            end else if (pick < 87) begin
                send_frame(make_frame(pick_word(), pick_word(), 1'b1),
                           $urandom_range(1, 7), 1'b1);
                synced = 1'b0;
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    send_beat(8'($urandom_range(255)), $urandom_range(99) < 20);
                end
                synced = 1'b0;
            end
        end
    endtask

    initial begin
        int base;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no restart flag after reset, negative zero, full-scale humidity
        send_frame(make_frame(16'hFFFF, 16'h8000, 1'b1), 8, 1'b0);
        // partial frame cut off by a restart
        send_frame(make_frame(16'h0101, 16'h0202, 1'b1), 2, 1'b1);
        send_frame(make_frame(16'h0000, 16'h7FFF, 1'b1), 8, 1'b1);
        // no flag after frame end, bad CRC
        send_frame(make_frame(16'h1234, 16'hFFFF, 1'b0), 8, 1'b0);
        drain();

        base = beats_sent;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            in_idle_pct   = phase_in_idle[ph];
            out_stall_pct = phase_out_stall[ph];
            random_traffic(base + (RANDOM_BEATS * (ph + 1)) / NUM_PHASES);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (readings.expected_readings.size() != 0) begin
            readings.report("frames left without a result");
        end
        if (readings.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
